// ===== sv/dda_line_rasterizer_unit_macros.svh =====
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_UNIT_MACROS_SVH
`define DDA_LINE_RASTERIZER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDA_ASSERT_SAME(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dda_pkg.sv =====
// Types and constants shared by the line rasterizer modules.
`timescale 1ns / 1ps

package dda_pkg;

  localparam int COORD_W        = 6;
  localparam int GRID_SIZE      = 64;
  localparam int JOB_FIFO_DEPTH = 2;
  // Signed remainder width: covers -2*steps up to just under 4*steps.
  localparam int REM_W          = COORD_W + 3;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } segment_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } pixel_t;

  // A classified segment, ready for the stepper.
  typedef struct packed {
    coord_t x_start;
    coord_t y_start;
    coord_t adx;
    coord_t ady;
    logic   dx_neg;
    logic   dy_neg;
    coord_t steps;
  } job_t;

endpackage

// ===== sv/dda_line_rasterizer_unit.sv =====
// Top level of the DDA line rasterizer.
`timescale 1ns / 1ps
// Usage:
// The input channel takes one segment word (two grid endpoints) when push is
// high and full is low. The output channel is read like a queue: while empty is
// low the oldest pixel word sits on pixel, and pop with empty low takes it.
// Each segment yields max(|dx|,|dy|)+1 pixel words from start to end, with
// last_pixel set on the final one. Endpoints beyond the grid are clamped.
// Path: the first pixel of a segment passes the front-end register, the job
// queue write and the stepper load before the output register is written.
// Throughput: the stepper emits one pixel per cycle unless the output stalls,
// once a segment is loaded, and loads the next one only after its last pixel.
// The front end and the two-entry job queue keep taking segments while the
// stepper works, so full rises only when all of them are occupied.
// When the receiver stalls the pixel word holds and the stepper pauses;
// nothing is lost. A synchronous reset on rst empties the queue and the output.

module dda_line_rasterizer_unit #(
  parameter int GRID_SIZE = dda_pkg::GRID_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dda_pkg::segment_t segment,
  output logic              empty,
  input  logic              pop,
  output dda_pkg::pixel_t   pixel
);

  logic          front_valid, fifo_ready, job_valid, job_ready;
  dda_pkg::job_t front_job, queued_job;

  // Clamp and classify each segment word.
  dda_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .segment  (segment),
    .job_valid(front_valid),
    .job_ready(fifo_ready),
    .job      (front_job)
  );

  // Decouples the front end from the stepper.
  dda_job_fifo #(
    .DEPTH(dda_pkg::JOB_FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(front_valid),
    .wr_ready(fifo_ready),
    .wr_job  (front_job),
    .rd_valid(job_valid),
    .rd_ready(job_ready),
    .rd_job  (queued_job)
  );

  // Incremental rounding walk; one pixel word per cycle unless the output stalls.
  dda_stepper u_stepper (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (queued_job),
    .empty    (empty),
    .pop      (pop),
    .pixel    (pixel)
  );

endmodule

// ===== sv/dda_front.sv =====
// Front end: accepts segments, clamps them to the grid and classifies them.
`timescale 1ns / 1ps

module dda_front #(
  parameter int GRID_SIZE = dda_pkg::GRID_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dda_pkg::segment_t segment,
  output logic              job_valid,
  input  logic              job_ready,
  output dda_pkg::job_t     job
);

  localparam dda_pkg::coord_t CoordMax = dda_pkg::COORD_W'(GRID_SIZE - 1);

  dda_pkg::coord_t xs, ys, xe, ye;
  dda_pkg::coord_t adx, ady;
  logic            dx_neg, dy_neg;
  dda_pkg::job_t   job_next;

  function automatic dda_pkg::coord_t clamp(input dda_pkg::coord_t v);
    clamp = (v > CoordMax) ? CoordMax : v;
  endfunction

  always_comb begin
    xs     = clamp(segment.x_start);
    ys     = clamp(segment.y_start);
    xe     = clamp(segment.x_end);
    ye     = clamp(segment.y_end);
    dx_neg = xe < xs;
    dy_neg = ye < ys;
    adx    = dx_neg ? (xs - xe) : (xe - xs);
    ady    = dy_neg ? (ys - ye) : (ye - ys);
    job_next.x_start = xs;
    job_next.y_start = ys;
    job_next.adx     = adx;
    job_next.ady     = ady;
    job_next.dx_neg  = dx_neg;
    job_next.dy_neg  = dy_neg;
    job_next.steps   = (adx > ady) ? adx : ady;
  end

  assign full = job_valid && !job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!full) begin
      job_valid <= push;
    end
    if (!full && push) begin
      job <= job_next;
    end
  end

endmodule

// ===== sv/dda_job_fifo.sv =====
// Short job queue between the front end and the stepper.
`timescale 1ns / 1ps
`include "dda_line_rasterizer_unit_macros.svh"

module dda_job_fifo #(
  parameter int DEPTH = dda_pkg::JOB_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  dda_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output dda_pkg::job_t rd_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dda_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ready = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  `DDA_ASSERT_SAME(a_fifo_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "job queue overfilled")

endmodule

// ===== sv/dda_stepper.sv =====
// Back end: walks one classified segment, a pixel per cycle unless stalled.
`timescale 1ns / 1ps
`include "dda_line_rasterizer_unit_macros.svh"

module dda_stepper (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  dda_pkg::job_t   job,
  output logic            empty,
  input  logic            pop,
  output dda_pkg::pixel_t pixel
);

  localparam int RW = dda_pkg::REM_W;

  dda_pkg::job_t          cur;
  logic                   busy;
  logic                   out_valid;
  dda_pkg::coord_t        x, y, cnt;
  logic signed [RW-1:0]   rx, ry;
  logic signed [RW-1:0]   rx_sum, ry_sum, two_adx, two_ady, two_steps;
  logic                   out_space, emit, last;

  assign empty     = !out_valid;
  assign job_ready = !busy;
  assign out_space = !out_valid || pop;
  assign emit      = busy && out_space;
  assign last      = cnt == cur.steps;

  always_comb begin
    two_adx   = RW'({cur.adx, 1'b0});
    two_ady   = RW'({cur.ady, 1'b0});
    two_steps = RW'({cur.steps, 1'b0});
    rx_sum    = cur.dx_neg ? (rx - two_adx) : (rx + two_adx);
    ry_sum    = cur.dy_neg ? (ry - two_ady) : (ry + two_ady);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The output word stays valid until popped, and a new one lands on emit.
      out_valid <= emit || (out_valid && !pop);
      if (emit) begin
        if (last) begin
          busy <= 1'b0;
        end
      end else if (!busy && job_valid) begin
        busy <= 1'b1;
      end
    end

    if (emit) begin
      pixel.pixel_x    <= x;
      pixel.pixel_y    <= y;
      pixel.last_pixel <= last;
      cnt              <= cnt + dda_pkg::COORD_W'(1);
      // The remainder stays in [0, 2*steps); one correction per step suffices.
      if (!cur.dx_neg && rx_sum >= two_steps) begin
        rx <= rx_sum - two_steps;
        x  <= x + dda_pkg::COORD_W'(1);
      end else if (cur.dx_neg && rx_sum < 0) begin
        rx <= rx_sum + two_steps;
        x  <= x - dda_pkg::COORD_W'(1);
      end else begin
        rx <= rx_sum;
      end
      if (!cur.dy_neg && ry_sum >= two_steps) begin
        ry <= ry_sum - two_steps;
        y  <= y + dda_pkg::COORD_W'(1);
      end else if (cur.dy_neg && ry_sum < 0) begin
        ry <= ry_sum + two_steps;
        y  <= y - dda_pkg::COORD_W'(1);
      end else begin
        ry <= ry_sum;
      end
    end else if (!busy && job_valid) begin
      cur <= job;
      x   <= job.x_start;
      y   <= job.y_start;
      cnt <= '0;
      rx  <= RW'(job.steps);
      ry  <= RW'(job.steps);
    end
  end

  `DDA_ASSERT_SAME(a_cnt_bound, clk, rst, busy, cnt <= cur.steps, "step count ran past the segment")
  `DDA_ASSERT_SAME(a_rem_range, clk, rst, busy && cur.steps != '0,
    rx >= 0 && rx < two_steps && ry >= 0 && ry < two_steps, "remainder left its range")
  `DDA_ASSERT_SAME(a_end_rem, clk, rst, emit && last,
    rx == RW'(cur.steps) && ry == RW'(cur.steps), "segment did not close on its end point")
  `DDA_ASSERT_NEXT(a_keep_busy, clk, rst, emit && !last, busy, "segment dropped before its last pixel")

endmodule
